>>> design/ritl_pkg.sv
// Package for row_index_to_letters: widths, constants, controller states and
// the command/status structs shared by the controller and the datapath.
// Depends on nothing.
`default_nettype none

package ritl_pkg;

    // Most letters emitted for one item
    localparam int MAX_LETTERS = 6;

    // Field widths
    localparam int IDX_W    = 29;
    localparam int LETTER_W = 7;
    localparam int DIG_W    = 5;
    localparam int REM_W    = DIG_W + 1;
    localparam int PTR_W    = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;

    localparam int RADIX    = 26;
    localparam int LETTER_A = 65;

    // Divide by 26 through a reciprocal: q0 = (x * RECIP) >> RECIP_SHIFT
    // falls short of x / 26 by at most one for any IDX_W-bit x.
    localparam int          RECIP_SHIFT = 33;
    localparam int          RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(330382099);
    localparam int          PROD_W      = IDX_W + RECIP_W;
    localparam int          Q_W         = PROD_W - RECIP_SHIFT;

    // Largest index that fits in MAX_LETTERS letters: 26 + 26^2 + ... - 1
    function automatic logic [63:0] sat_limit_f();
        logic [63:0] power;
        logic [63:0] sum;
        power = 64'd1;
        sum   = 64'd0;
        for (int k = 0; k < MAX_LETTERS; k++)
        begin
            power = power * 64'(RADIX);
            sum   = sum + power;
        end
        return sum - 64'd1;
    endfunction

    localparam logic [63:0] SAT_LIMIT = sat_limit_f();

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIG,
        S_EMIT
    } ritl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // take a new index, saturate it, reset the digit pointer
        logic mul;     // register the reciprocal product
        logic dig;     // correct the quotient, store one digit
        logic step;    // one letter taken downstream: move to the next one
    } ritl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_dig;  // digit being stored is the most significant one
        logic emit_done; // letter on the output is the least significant one
    } ritl_status_t;

endpackage

`default_nettype wire

>>> design/row_index_to_letters.sv
// Top level of row_index_to_letters: joins the controller and the datapath.
// Depends on ritl_pkg, ritl_ctrl and ritl_dpath.
`default_nettype none

// Converts a zero-based row index into spreadsheet column letters in bijective
// base 26 (0..25 give A..Z, 26 gives AA, 702 gives AAA). Each index taken on
// the input channel produces one to six items on the output channel, each
// carrying the ASCII code of a capital letter, most significant letter first;
// last_letter marks the final one. Indexes above 321272405 saturate to
// ZZZZZZ. One index is handled at a time: the input stalls from acceptance
// until the final letter has been taken. Digits are peeled off least
// significant first by a shared divide-by-26 unit (a registered reciprocal
// product followed by a one-step correction), and are then replayed from a
// small digit store one letter per cycle while the output is not stalled.
// No state is kept between items, and reset returns the block to idle at once.

module row_index_to_letters
    import ritl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [IDX_W-1:0]    row_index,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [LETTER_W-1:0]      letter_code,
    output logic                     last_letter
);

    ritl_cmd_t    cmd;
    ritl_status_t status;

    // Sequencing: idle, then multiply/correct per letter, then emit
    ritl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic, digit store and output letter
    ritl_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .row_index   (row_index),
        .letter_code (letter_code),
        .last_letter (last_letter)
    );

endmodule

`default_nettype wire

>>> design/ritl_ctrl.sv
// Controller for row_index_to_letters: sequences load, digit extraction and
// letter emission. Depends on ritl_pkg.
`default_nettype none

module ritl_ctrl
    import ritl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    input  wire ritl_status_t status,
    output ritl_cmd_t         cmd
);

    ritl_state_t state_reg;
    ritl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIG;
            end
            S_DIG:
            begin
                state_next = status.last_dig ? S_EMIT : S_MUL;
            end
            S_EMIT:
            begin
                if (!out_stall && status.emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_DIG:
            begin
                cmd.dig = 1'b1;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                cmd.step  = !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // An offered index is always taken from idle and starts the extraction
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_MUL))
        else $error("accepted index did not start extraction");

    // Taking the final letter returns the controller to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && status.emit_done) |=> (state_reg == S_IDLE))
        else $error("controller not idle after final letter");

    // Nothing is accepted while letters are still being produced
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid || cmd.mul || cmd.dig) |-> in_stall)
        else $error("input accepted during extraction or emission");

endmodule

`default_nettype wire

>>> design/ritl_dpath.sv
// Datapath for row_index_to_letters: saturation, divide-by-26 through a
// reciprocal product, digit store and letter output. Depends on ritl_pkg.
`default_nettype none

module ritl_dpath
    import ritl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ritl_cmd_t          cmd,
    output ritl_status_t            status,
    input  wire logic [IDX_W-1:0]   row_index,
    output logic [LETTER_W-1:0]     letter_code,
    output logic                    last_letter
);

    logic [IDX_W-1:0] x_reg;
    logic [IDX_W-1:0] x_next;
    logic [Q_W-1:0]   q_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [DIG_W-1:0] digit_reg [MAX_LETTERS];

    logic             sat;
    logic [PROD_W-1:0] prod;
    logic [IDX_W:0]   q26;
    logic [IDX_W:0]   rem_full;
    logic [REM_W-1:0] rem;
    logic             rem_high;
    logic [Q_W-1:0]   q_fix;
    logic [DIG_W-1:0] dig_val;

    assign sat = {{(64 - IDX_W){1'b0}}, row_index} > SAT_LIMIT;

    assign prod = PROD_W'(x_reg) * PROD_W'(RECIP);

    // Remainder of the estimate lies below twice the radix: one correction
    assign q26      = (IDX_W + 1)'(q_reg) * (IDX_W + 1)'(RADIX);
    assign rem_full = {1'b0, x_reg} - q26;
    assign rem      = rem_full[REM_W-1:0];
    assign rem_high = rem >= REM_W'(RADIX);
    assign q_fix    = q_reg + Q_W'(rem_high);
    assign dig_val  = rem_high ? DIG_W'(rem - REM_W'(RADIX)) : DIG_W'(rem);

    always_comb
    begin
        x_next   = x_reg;
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            x_next   = sat ? SAT_LIMIT[IDX_W-1:0] : row_index;
            ptr_next = '0;
        end
        else if (cmd.dig)
        begin
            // Bijective step: drop one before the next division
            x_next = IDX_W'(q_fix) - IDX_W'(1);
            if (!status.last_dig)
            begin
                ptr_next = ptr_reg + PTR_W'(1);
            end
        end
        else if (cmd.step && !status.emit_done)
        begin
            ptr_next = ptr_reg - PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (cmd.mul)
        begin
            q_reg <= prod[PROD_W-1:RECIP_SHIFT];
        end
        if (cmd.dig)
        begin
            digit_reg[ptr_reg] <= dig_val;
        end
    end

    assign status.last_dig  = (q_fix == '0) || (ptr_reg == PTR_W'(MAX_LETTERS - 1));
    assign status.emit_done = (ptr_reg == '0);

    assign letter_code = LETTER_W'(LETTER_A) + LETTER_W'(digit_reg[ptr_reg]);
    assign last_letter = status.emit_done;

    // Quotient estimate is never more than one short
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dig |-> (rem_full < (IDX_W + 1)'(2 * RADIX)))
        else $error("reciprocal quotient estimate out of range");

    // Stored digit is a valid base-26 digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dig |-> (dig_val < DIG_W'(RADIX)))
        else $error("digit out of range");

    // Digit pointer stays inside the store
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(MAX_LETTERS - 1))
        else $error("digit pointer beyond store");

endmodule

`default_nettype wire

>>> verif/tb.sv
// Testbench for row_index_to_letters: drives row indexes, predicts the
// bijective base-26 letters of each one and checks every letter item.
// Depends on ritl_pkg and the row_index_to_letters RTL.
`timescale 1ns / 1ps

module tb
    import ritl_pkg::*;
();

    localparam int  QUIET_LIMIT  = 2000;   // cycles with no item moving before giving up
    localparam int  IDLE_PERCENT = 9;
    localparam int  RANDOM_ROWS  = 446;
    localparam int  STEADY_FROM  = 180;    // rows taken: start of the window with no idling
    localparam int  STEADY_TO    = 290;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // One pending row index; drain_first holds it back until every
    // outstanding letter has come out.
    typedef struct {
        logic [IDX_W-1:0] row;
        logic             drain_first;
    } row_req_t;

    // One expected letter item
    typedef struct {
        logic [LETTER_W-1:0] code;
        logic                last;
    } letter_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [IDX_W-1:0]    row_index = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [LETTER_W-1:0] letter_code;
    logic                last_letter;

    row_req_t pending_rows[$];
    letter_t  expected_letters[$];

    int rows_taken = 0;
    int letters_checked = 0;
    int saturated_rows = 0;
    int rows_by_length[1:MAX_LETTERS];
    int failures = 0;
    int quiet_cycles = 0;

    row_index_to_letters dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .row_index   (row_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .letter_code (letter_code),
        .last_letter (last_letter)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Inside the steady window neither side idles, so the block runs flat out.
    function automatic logic take_a_break();
        if (rows_taken >= STEADY_FROM && rows_taken < STEADY_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    // First index that needs n letters; n = MAX_LETTERS + 1 gives the
    // first index that saturates.
    function automatic longint first_index_of_len(int n);
        longint power;
        longint sum;
        power = 1;
        sum   = 0;
        for (int k = 1; k < n; k++)
        begin
            power = power * RADIX;
            sum   = sum + power;
        end
        return sum;
    endfunction

    // Work out the letters of one accepted row index and queue them,
    // most significant first. Saturate indexes beyond six letters.
    function automatic void spell_row_letters(logic [IDX_W-1:0] row);
        logic [63:0]      remaining;
        logic [DIG_W-1:0] digit [MAX_LETTERS];
        int               count;
        letter_t          item;
        count = 0;
        if (64'(row) > SAT_LIMIT)
        begin
            remaining = SAT_LIMIT + 64'd1;
            saturated_rows++;
        end
        else
            remaining = 64'(row) + 64'd1;
        // peel digits off least significant first: subtract one, then divide
        while (remaining != 64'd0 && count < MAX_LETTERS)
        begin
            remaining    = remaining - 64'd1;
            digit[count] = DIG_W'(remaining % 64'(RADIX));
            remaining    = remaining / 64'(RADIX);
            count++;
        end
        for (int k = count - 1; k >= 0; k--)
        begin
            item.code = LETTER_W'(LETTER_A) + LETTER_W'(digit[k]);
            item.last = (k == 0);
            expected_letters.push_back(item);
        end
        rows_by_length[count]++;
    endfunction

    // Driver: present the next pending row, hold it while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            row_index <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                spell_row_letters(row_index);
                rows_taken++;
            end
            // a stalled item stays put; otherwise pick the next one or idle
            if (!in_valid || !in_stall)
            begin
                if (pending_rows.size() > 0 && !take_a_break()
                    && (!pending_rows[0].drain_first || expected_letters.size() == 0))
                begin
                    in_valid  <= 1'b1;
                    row_index <= pending_rows[0].row;
                    void'(pending_rows.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random and check every letter item taken.
    always @(posedge clk or negedge rst_n)
    begin
        letter_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_letters.size() == 0)
                begin
                    $display("%0t: unexpected letter item: code %0d last %0b",
                             $time, letter_code, last_letter);
                    failures++;
                end
                else
                begin
                    want = expected_letters.pop_front();
                    if (letter_code !== want.code)
                    begin
                        $display("%0t: letter_code expected %0d, got %0d",
                                 $time, want.code, letter_code);
                        failures++;
                    end
                    if (last_letter !== want.last)
                    begin
                        $display("%0t: last_letter expected %0b, got %0b",
                                 $time, want.last, last_letter);
                        failures++;
                    end
                    letters_checked++;
                end
            end
            out_stall <= take_a_break();
        end
    end

    // Watchdog: give up when no item has moved on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d letters still awaited",
                         $time, QUIET_LIMIT, expected_letters.size());
                $display("row_index_to_letters: mismatch");
                $finish;
            end
        end
    end

    // Stimulus: directed corners first, then random rows, then drain and report.
    initial
    begin
        row_req_t req;
        longint   lo;
        longint   hi;
        longint   pick;
        int       len;
        static logic [IDX_W-1:0] corners[] = '{
            IDX_W'(0), IDX_W'(1), IDX_W'(25), IDX_W'(26), IDX_W'(27),
            IDX_W'(51), IDX_W'(52), IDX_W'(675), IDX_W'(701), IDX_W'(702),
            IDX_W'(703), IDX_W'(18277), IDX_W'(18278), IDX_W'(475253),
            IDX_W'(475254), IDX_W'(12356629), IDX_W'(12356630),
            IDX_W'(321272404), IDX_W'(321272405), IDX_W'(321272406),
            IDX_W'('h0AAAAAAA), IDX_W'('h15555555), IDX_W'('h10000000), IDX_MAX
        };

        for (int n = 1; n <= MAX_LETTERS; n++)
            rows_by_length[n] = 0;

        // corners: every letter-count boundary, the saturation edge, full scale
        foreach (corners[i])
        begin
            req.row         = corners[i];
            req.drain_first = 1'b0;
            pending_rows.push_back(req);
        end

        for (int i = 0; i < RANDOM_ROWS; i++)
        begin
            // the first random row waits for the corners to drain completely
            req.drain_first = (i == 0) || ($urandom_range(99) < 2);
            case ($urandom_range(3))
                0: req.row = IDX_W'($urandom);
                1:
                begin
                    // uniform within the band of one letter count
                    len = $urandom_range(MAX_LETTERS, 1);
                    lo  = first_index_of_len(len);
                    hi  = first_index_of_len(len + 1) - 1;
                    req.row = IDX_W'(lo + longint'($urandom) % (hi - lo + 1));
                end
                2:
                begin
                    // hug a boundary between letter counts or saturation
                    len  = $urandom_range(MAX_LETTERS + 1, 2);
                    pick = first_index_of_len(len) + longint'($urandom_range(6)) - 3;
                    req.row = IDX_W'(pick);
                end
                default: req.row = IDX_W'($urandom_range(1000));
            endcase
            pending_rows.push_back(req);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // sample between edges so the driver's updates have all landed
        do
            @(negedge clk);
        while (pending_rows.size() != 0 || in_valid || expected_letters.size() != 0);
        repeat (25) @(posedge clk);

        $display("Converted %0d row indexes (%0d saturated) into %0d letters;",
                 rows_taken, saturated_rows, letters_checked);
        $display("rows by letter count 1..6: %0d %0d %0d %0d %0d %0d",
                 rows_by_length[1], rows_by_length[2], rows_by_length[3],
                 rows_by_length[4], rows_by_length[5], rows_by_length[6]);
        if (failures == 0 && expected_letters.size() == 0)
            $display("row_index_to_letters: match");
        else
            $display("row_index_to_letters: mismatch");
        $finish;
    end

endmodule
